>>> src/bcmp_pkg.sv
// Package for the barometer compensation core: field widths, register
// indexes and the fixed constants of the integer compensation scheme.
// No dependencies.
`timescale 1ns / 1ps

package bcmp_pkg;

	// Register indexes of the configuration port
	localparam logic [2:0] RegOss  = 3'd0;
	localparam logic [2:0] RegAc12 = 3'd1;
	localparam logic [2:0] RegAc34 = 3'd2;
	localparam logic [2:0] RegAc56 = 3'd3;
	localparam logic [2:0] RegB12  = 3'd4;
	localparam logic [2:0] RegMcMd = 3'd5;

	// Stream widths
	localparam int InDataW  = 40;
	localparam int OutDataW = 40;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 32;

	// Divider geometry: dividend widths must be a multiple of the step
	localparam int TempDivNumW = 28;
	localparam int TempDivDenW = 20;
	localparam int PresDivNumW = 32;
	localparam int PresDivDenW = 17;
	localparam int DivStep     = 4;

	// Compensation constants
	localparam int TRef     = 4000;
	localparam int PScale   = 50000;
	localparam int COffset  = 32768;
	localparam int CSquare  = 3038;
	localparam int CLinear  = 7357;
	localparam int CBias    = 3791;
	localparam int TMax     = 32767;
	localparam int TMin     = -32768;
	localparam int PMax     = 1048575;

endpackage

>>> src/bcmp_udiv.sv
// Pipelined unsigned restoring divider, STEP quotient bits per stage.
// Used by the barometer compensation core; depends on nothing else.
`timescale 1ns / 1ps

module bcmp_udiv #(
	parameter int NW   = 32,
	parameter int DW   = 17,
	parameter int STEP = 4
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo
);

	localparam int NS = NW / STEP;

	logic [DW-1:0] rem_q [NS];
	logic [NW-1:0] sh_q  [NS];
	logic [DW-1:0] den_q [NS];

	for (genvar s = 0; s < NS; s++) begin : g_stage
		logic [DW-1:0] r_in;
		logic [NW-1:0] n_in;
		logic [DW-1:0] d_in;
		logic [DW-1:0] r_nx;
		logic [NW-1:0] n_nx;

		if (s == 0) begin : g_first
			assign r_in = '0;
			assign n_in = num;
			assign d_in = den;
		end else begin : g_next
			assign r_in = rem_q[s-1];
			assign n_in = sh_q[s-1];
			assign d_in = den_q[s-1];
		end

		// Shift in dividend bits, subtract when the trial fits
		always_comb begin
			logic [DW:0] trial;
			r_nx = r_in;
			n_nx = n_in;
			trial = '0;
			for (int b = 0; b < STEP; b++) begin
				trial = {r_nx, n_nx[NW-1]};
				n_nx = {n_nx[NW-2:0], 1'b0};
				if (trial >= {1'b0, d_in}) begin
					trial = trial - {1'b0, d_in};
					n_nx[0] = 1'b1;
				end
				r_nx = trial[DW-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[s] <= r_nx;
				sh_q[s]  <= n_nx;
				den_q[s] <= d_in;
			end
		end
	end

	assign quo = sh_q[NS-1];

endmodule

>>> src/bcmp_delay.sv
// Stallable shift line that carries side data alongside a divider.
// Used by the barometer compensation core; depends on nothing else.
`timescale 1ns / 1ps

module bcmp_delay #(
	parameter int W = 8,
	parameter int N = 4
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] tap_q [N];

	// Advance the line when the pipeline moves
	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= din;
			for (int i = 1; i < N; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign dout = tap_q[N-1];

endmodule

>>> src/barometer_compensation_core.sv
// Barometer compensation core: a stream of raw temperature/pressure pairs in,
// compensated temperature (0.1 degC) and pressure (Pa) out.
// Depends on bcmp_pkg, bcmp_udiv and bcmp_delay.
//
// Usage:
//   s_tdata carries one raw reading pair per item; m_tdata carries one
//   compensated result per item, m_tuser flags a zero divisor (both results
//   then read zero). Calibration and oversampling are written through
//   cfg_we/cfg_index/cfg_wdata while no item is in flight.
// Throughput:
//   One item per cycle while the output is not stalled. The pipeline holds
//   two pipelined dividers, for the temperature quotient and the pressure
//   quotient, DIV_STEP bits per stage.
// Reset:
//   arst_n clears all valid bits and resets the configuration registers to
//   zero; data registers hold no meaning until their valid bit is set.
// Stall:
//   When m_tready is low with a result waiting, the whole pipeline holds;
//   s_tready drops with it, and nothing is lost or repeated. Bubbles in
//   the pipeline still advance while the output is empty.
`timescale 1ns / 1ps

module barometer_compensation_core
	import bcmp_pkg::*;
#(
	parameter int DIV_STEP = DivStep // 1, 2 or 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,  // raw_temperature[15:0], raw_pressure[34:16]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,  // temperature_tenths[15:0], pressure_pa[35:16]
	output logic [0:0]          m_tuser,  // math_fault[0]
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata
);

	localparam int LT    = TempDivNumW / DIV_STEP;
	localparam int LP    = PresDivNumW / DIV_STEP;
	localparam int DEPTH = 14 + LT + LP;

	// Configuration registers
	logic [1:0]  oss_q;
	logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oss_q  <= '0;
			ac12_q <= '0;
			ac34_q <= '0;
			ac56_q <= '0;
			b12_q  <= '0;
			mcmd_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegOss:  oss_q  <= cfg_wdata[1:0];
				RegAc12: ac12_q <= cfg_wdata;
				RegAc34: ac34_q <= cfg_wdata;
				RegAc56: ac56_q <= cfg_wdata;
				RegB12:  b12_q  <= cfg_wdata;
				RegMcMd: mcmd_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic signed [15:0] ac1, ac2, ac3, cb1, cb2, cmc, cmd;
	logic [15:0]        ac4;
	logic signed [16:0] ac5s, ac6s;

	assign ac1  = $signed(ac12_q[31:16]);
	assign ac2  = $signed(ac12_q[15:0]);
	assign ac3  = $signed(ac34_q[31:16]);
	assign ac4  = ac34_q[15:0];
	assign ac5s = $signed({1'b0, ac56_q[31:16]});
	assign ac6s = $signed({1'b0, ac56_q[15:0]});
	assign cb1  = $signed(b12_q[31:16]);
	assign cb2  = $signed(b12_q[15:0]);
	assign cmc  = $signed(mcmd_q[31:16]);
	assign cmd  = $signed(mcmd_q[15:0]);

	// Pipeline control: advance unless a result waits
	logic             en;
	logic [DEPTH-1:0] vld_q;

	assign en       = !vld_q[DEPTH-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], s_tvalid};
		end
	end

	// Stage 1: (UT - AC6) * AC5
	logic signed [16:0] d_ut;
	logic signed [33:0] prod_s1;
	logic [18:0]        up_s1;

	assign d_ut = $signed({1'b0, s_tdata[15:0]}) - ac6s;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 34'(d_ut) * 34'(ac5s);
			up_s1   <= s_tdata[34:16];
		end
	end

	// Stage 2: X1, divisor, magnitudes for the temperature quotient
	logic signed [18:0] lin;
	logic signed [19:0] den;
	logic [15:0]        cabs;
	logic [TempDivNumW-1:0] tnum_s2;
	logic [TempDivDenW-1:0] tden_s2;
	logic signed [18:0] lin_s2;
	logic               neg_s2, ftemp_s2;
	logic [18:0]        up_s2;

	assign lin  = $signed(prod_s1[33:15]);
	assign den  = 20'(lin) + 20'(cmd);
	assign cabs = cmc[15] ? 16'(-17'(cmc)) : 16'(cmc);

	always_ff @(posedge clk) begin
		if (en) begin
			tnum_s2  <= TempDivNumW'({cabs, 11'b0});
			tden_s2  <= den[19] ? 20'(-den) : 20'(den);
			lin_s2   <= lin;
			neg_s2   <= cmc[15] ^ den[19];
			ftemp_s2 <= (den == '0);
			up_s2    <= up_s1;
		end
	end

	// Temperature quotient, side data alongside
	logic [TempDivNumW-1:0] tquo;
	logic [20:0]            tside;
	logic [18:0]            up_s7;

	bcmp_udiv #(.NW(TempDivNumW), .DW(TempDivDenW), .STEP(DIV_STEP)) u_tdiv (
		.clk (clk),
		.en  (en),
		.num (tnum_s2),
		.den (tden_s2),
		.quo (tquo)
	);

	bcmp_delay #(.W(21), .N(LT)) u_tside (
		.clk  (clk),
		.en   (en),
		.din  ({ftemp_s2, neg_s2, lin_s2}),
		.dout (tside)
	);

	bcmp_delay #(.W(19), .N(LT + 5)) u_upd (
		.clk  (clk),
		.en   (en),
		.din  (up_s2),
		.dout (up_s7)
	);

	// Stage 3: B5, temperature result, B6
	logic signed [27:0] qs, mid, ttw;
	logic signed [15:0] tt_s3;
	logic               ftemp_s3;
	logic signed [27:0] dt_s3;

	assign qs  = tside[19] ? -$signed(tquo) : $signed(tquo);
	assign mid = 28'($signed(tside[18:0])) + qs;
	assign ttw = (mid + 28'sd8) >>> 4;

	always_ff @(posedge clk) begin
		if (en) begin
			if (ttw > 28'(TMax)) begin
				tt_s3 <= 16'(TMax);
			end else if (ttw < 28'(TMin)) begin
				tt_s3 <= 16'(TMin);
			end else begin
				tt_s3 <= ttw[15:0];
			end
			ftemp_s3 <= tside[20];
			dt_s3    <= mid - 28'(TRef);
		end
	end

	// Stage 4: B6 squared and the linear B6 products
	logic signed [55:0] sqf_s4;
	logic signed [43:0] b2p_s4, a3p_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sqf_s4 <= 56'(dt_s3) * 56'(dt_s3);
			b2p_s4 <= 44'(ac2) * 44'(dt_s3);
			a3p_s4 <= 44'(ac3) * 44'(dt_s3);
		end
	end

	// Stage 5: products with the scaled square
	logic signed [43:0] sq;
	logic signed [59:0] pa_s5, pb_s5;
	logic signed [32:0] b2_s5;
	logic signed [30:0] a3_s5;

	assign sq = $signed(sqf_s4[55:12]);

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s5 <= 60'(cb2) * 60'(sq);
			pb_s5 <= 60'(cb1) * 60'(sq);
			b2_s5 <= $signed(b2p_s4[43:11]);
			a3_s5 <= $signed(a3p_s4[43:13]);
		end
	end

	// Stage 6: offset sum and scale term X3
	logic signed [48:0] aoff;
	logic signed [43:0] cbt;
	logic signed [45:0] csum;
	logic signed [50:0] sum_s6;
	logic [31:0]        c32_s6;

	assign aoff = $signed(pa_s5[59:11]);
	assign cbt  = $signed(pb_s5[59:16]);
	assign csum = 46'(a3_s5) + 46'(cbt) + 46'sd2;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s6 <= (51'(ac1) <<< 2) + 51'(aoff) + 51'(b2_s5);
			c32_s6 <= csum[33:2] + 32'(COffset);
		end
	end

	// Stage 7: B3, truncated toward zero
	logic signed [53:0] xo, yo, yb;
	logic [31:0]        off_s7, c32_s7;

	assign xo = 54'(sum_s6) <<< oss_q;
	assign yo = xo + 54'sd2;
	assign yb = yo[53] ? yo + 54'sd3 : yo;

	always_ff @(posedge clk) begin
		if (en) begin
			off_s7 <= yb[33:2];
			c32_s7 <= c32_s6;
		end
	end

	// Stage 8: B4 and UP - B3
	logic [47:0] sclp;
	logic [16:0] scl_s8;
	logic [31:0] diff_s8;

	assign sclp = 48'(ac4) * 48'(c32_s7);

	always_ff @(posedge clk) begin
		if (en) begin
			scl_s8  <= sclp[31:15];
			diff_s8 <= 32'(up_s7) - off_s7;
		end
	end

	// Stage 9: B7
	logic [15:0] kp;
	logic [31:0] num_s9;
	logic [16:0] scl_s9;
	logic        fpres_s9;

	assign kp = 16'(PScale >> oss_q);

	always_ff @(posedge clk) begin
		if (en) begin
			num_s9   <= diff_s8 * 32'(kp);
			scl_s9   <= scl_s8;
			fpres_s9 <= (scl_s8 == '0);
		end
	end

	// Stage 10: choose dividend form by the top bit of B7
	logic [31:0] dvd_s10;
	logic [16:0] scl_s10;
	logic        big_s10, fpres_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			big_s10   <= num_s9[31];
			dvd_s10   <= num_s9[31] ? num_s9 : {num_s9[30:0], 1'b0};
			scl_s10   <= scl_s9;
			fpres_s10 <= fpres_s9;
		end
	end

	// Pressure quotient, side data alongside
	logic [PresDivNumW-1:0] pquo;
	logic [1:0]             pside;
	logic [16:0]            tres_d;

	bcmp_udiv #(.NW(PresDivNumW), .DW(PresDivDenW), .STEP(DIV_STEP)) u_pdiv (
		.clk (clk),
		.en  (en),
		.num (dvd_s10),
		.den (scl_s10),
		.quo (pquo)
	);

	bcmp_delay #(.W(2), .N(LP)) u_pside (
		.clk  (clk),
		.en   (en),
		.din  ({fpres_s10, big_s10}),
		.dout (pside)
	);

	bcmp_delay #(.W(17), .N(LP + 10)) u_tres (
		.clk  (clk),
		.en   (en),
		.din  ({ftemp_s3, tt_s3}),
		.dout (tres_d)
	);

	// Stage 11: raw pressure, X1 source and the linear product
	logic [32:0]        pa0;
	logic [32:0]        pa0_s11;
	logic [24:0]        ap_s11;
	logic signed [47:0] m7_s11;
	logic               fpres_s11;

	assign pa0 = pside[0] ? {pquo, 1'b0} : {1'b0, pquo};

	always_ff @(posedge clk) begin
		if (en) begin
			pa0_s11   <= pa0;
			ap_s11    <= pa0[32:8];
			m7_s11    <= 48'($signed({1'b0, pa0})) * -48'(CLinear);
			fpres_s11 <= pside[1];
		end
	end

	// Stage 12: square of the scaled pressure
	logic [49:0]        aa_s12;
	logic signed [31:0] bp_s12;
	logic [32:0]        pa0_s12;
	logic               fpres_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			aa_s12    <= 50'(ap_s11) * 50'(ap_s11);
			bp_s12    <= $signed(m7_s11[47:16]);
			pa0_s12   <= pa0_s11;
			fpres_s12 <= fpres_s11;
		end
	end

	// Stage 13: weight the square
	logic [61:0]        aa3;
	logic [45:0]        ap_s13;
	logic signed [31:0] bp_s13;
	logic [32:0]        pa0_s13;
	logic               fpres_s13;

	assign aa3 = 62'(aa_s12) * 62'(CSquare);

	always_ff @(posedge clk) begin
		if (en) begin
			ap_s13    <= aa3[61:16];
			bp_s13    <= bp_s12;
			pa0_s13   <= pa0_s12;
			fpres_s13 <= fpres_s12;
		end
	end

	// Stage 14: final correction, saturation and fault masking
	logic signed [46:0] tcor, corr;
	logic signed [47:0] pfin;
	logic               fault;
	logic [15:0]        tt_s14;
	logic [19:0]        pp_s14;
	logic               fault_s14;

	assign tcor  = 47'($signed({1'b0, ap_s13})) + 47'(bp_s13) + 47'(CBias);
	assign corr  = tcor >>> 4;
	assign pfin  = 48'($signed({1'b0, pa0_s13})) + 48'(corr);
	assign fault = tres_d[16] | fpres_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			fault_s14 <= fault;
			tt_s14    <= fault ? '0 : tres_d[15:0];
			if (fault || pfin[47]) begin
				pp_s14 <= '0;
			end else if (pfin > 48'(PMax)) begin
				pp_s14 <= 20'(PMax);
			end else begin
				pp_s14 <= pfin[19:0];
			end
		end
	end

	assign m_tdata = {4'b0, pp_s14, tt_s14};
	assign m_tuser = fault_s14;

endmodule

>>> test/barometer_compensation_checker.sv
// Checker for the barometer compensation core: mirrors the configuration
// writes, predicts one compensated result per accepted raw item and compares.
// Depends on bcmp_pkg.
`timescale 1ns / 1ps

module barometer_compensation_checker
	import bcmp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,  // raw_temperature[15:0], raw_pressure[34:16]
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [OutDataW-1:0] m_tdata,  // temperature_tenths[15:0], pressure_pa[35:16]
	input  logic [0:0]          m_tuser,  // math_fault[0]
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata,
	output int                  mismatches,
	output int                  pending
);

	typedef struct packed {
		logic [15:0] temp;
		logic [19:0] pres;
		logic        fault;
	} reading_t;

	logic [1:0]  oss_q;
	logic [31:0] coeff_q [1:5];
	reading_t    expected_readings [$];

	// Integer compensation: temperature first, its mid term feeds pressure
	function automatic reading_t compensate(input logic [15:0] ut, input logic [18:0] up);
		longint ac1, ac2, ac3, ac4, ac5, ac6, cb1, cb2, cmc, cmd;
		longint lin, den, mid, tt, dt, sq, a, b, c, off, pa;
		bit [31:0] cterm, prod, scl, num, quo;
		reading_t r;
		r = '0;
		r.fault = 1'b1;
		ac1 = longint'($signed(coeff_q[1][31:16]));
		ac2 = longint'($signed(coeff_q[1][15:0]));
		ac3 = longint'($signed(coeff_q[2][31:16]));
		ac4 = longint'(coeff_q[2][15:0]);
		ac5 = longint'(coeff_q[3][31:16]);
		ac6 = longint'(coeff_q[3][15:0]);
		cb1 = longint'($signed(coeff_q[4][31:16]));
		cb2 = longint'($signed(coeff_q[4][15:0]));
		cmc = longint'($signed(coeff_q[5][31:16]));
		cmd = longint'($signed(coeff_q[5][15:0]));

		lin = ((longint'(ut) - ac6) * ac5) >>> 15;
		den = lin + cmd;
		if (den == 0)
			return r;
		mid = lin + (cmc * 2048) / den;
		tt  = (mid + 8) >>> 4;

		dt  = mid - TRef;
		sq  = (dt * dt) >>> 12;
		a   = (cb2 * sq) >>> 11;
		b   = (ac2 * dt) >>> 11;
		off = ((ac1 * 4 + a + b) * (longint'(1) << oss_q) + 2) / 4;
		a   = (ac3 * dt) >>> 13;
		b   = (cb1 * sq) >>> 16;
		c   = (a + b + 2) >>> 2;
		cterm = 32'(c + COffset);
		prod  = 32'(ac4) * cterm;
		scl   = prod >> 15;
		if (scl == 0)
			return r;
		num = (32'(up) - 32'(off)) * (32'd50000 >> oss_q);
		if (num < 32'h8000_0000) begin
			quo = (num << 1) / scl;
			pa  = longint'(quo);
		end else begin
			quo = num / scl;
			pa  = longint'(quo) * 2;
		end

		a  = pa >>> 8;
		a  = (a * a * CSquare) >>> 16;
		b  = (-CLinear * pa) >>> 16;
		pa = pa + ((a + b + CBias) >>> 4);

		if (tt > TMax) tt = TMax;
		if (tt < TMin) tt = TMin;
		if (pa > PMax) pa = PMax;
		if (pa < 0) pa = 0;
		r.temp  = tt[15:0];
		r.pres  = pa[19:0];
		r.fault = 1'b0;
		return r;
	endfunction

	// Track configuration, queue predictions, compare results
	always @(posedge clk or negedge arst_n) begin
		reading_t want, got;
		if (!arst_n) begin
			oss_q <= '0;
			for (int i = 1; i <= 5; i++)
				coeff_q[i] <= '0;
			expected_readings.delete();
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_readings.push_back(compensate(s_tdata[15:0], s_tdata[34:16]));
			if (m_tvalid && m_tready) begin
				got.temp  = m_tdata[15:0];
				got.pres  = m_tdata[35:16];
				got.fault = m_tuser[0];
				if (expected_readings.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected item: temp=%0d pres=%0d fault=%0d",
							$signed(got.temp), got.pres, got.fault);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_readings.pop_front();
					if (want != got) begin
						if (mismatches < 10)
							$display("mismatch: exp temp=%0d pres=%0d fault=%0d, got temp=%0d pres=%0d fault=%0d",
								$signed(want.temp), want.pres, want.fault,
								$signed(got.temp), got.pres, got.fault);
						mismatches <= mismatches + 1;
					end
				end
			end
			pending <= expected_readings.size();
			if (cfg_we) begin
				if (cfg_index == RegOss)
					oss_q <= cfg_wdata[1:0];
				else if (cfg_index <= RegMcMd)
					coeff_q[cfg_index] <= cfg_wdata;
			end
		end
	end

endmodule

>>> test/barometer_compensation_core_tb.sv
// Testbench top for the barometer compensation core: clock, reset, stimulus
// and verdict. Depends on bcmp_pkg, the core and barometer_compensation_checker.
`timescale 1ns / 1ps

module barometer_compensation_core_tb;
	import bcmp_pkg::*;

	localparam int StallLimit = 5000;
	localparam int Settle     = 40;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;
	logic [0:0]          m_tuser;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_wdata = '0;
	int                  mismatches;
	int                  pending;
	bit                  quiet = 1'b0;
	int                  stall_cycles = 0;
	int                  sink_hold = 0;

	barometer_compensation_core u_dut (.*);

	barometer_compensation_checker u_chk (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Sink side: random stall bursts, none in the quiet tail
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			sink_hold <= $urandom_range(0, 4);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= StallLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Load oversampling and all five coefficient words
	task automatic load_calibration(input logic [31:0] oss, input logic [31:0] c1,
		input logic [31:0] c2, input logic [31:0] c3, input logic [31:0] c4,
		input logic [31:0] c5);
		write_reg(RegOss, oss);
		write_reg(RegAc12, c1);
		write_reg(RegAc34, c2);
		write_reg(RegAc56, c3);
		write_reg(RegB12, c4);
		write_reg(RegMcMd, c5);
	endtask

	// Wait for every prediction to be matched, then let the pipe settle
	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		repeat (Settle) @(negedge clk);
	endtask

	task automatic send_reading(input logic [15:0] ut, input logic [18:0] up);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 5);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, up, ut};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic end_burst();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// Random readings: mostly near the usual sensor range, some full range
	task automatic random_readings(input int n);
		logic [15:0] ut;
		logic [18:0] up;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) != 0) begin
				ut = 16'($urandom_range(20000, 36000));
				up = 19'($urandom_range(15000, 200000));
			end else begin
				ut = 16'($urandom);
				up = 19'($urandom);
			end
			send_reading(ut, up);
		end
		end_burst();
	endtask

	initial begin
		logic [31:0] c1, c2, c3, c4, c5;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// All-zero calibration: zero temperature divisor
		send_reading(16'd0, 19'd0);
		send_reading(16'hFFFF, 19'h7FFFF);
		end_burst();
		drain();

		// Typical calibration, every oversampling setting, field extremes
		for (int o = 0; o < 4; o++) begin
			load_calibration(32'(o) | 32'hFFFF_FFFC * (o == 3),
				{16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
				{16'd32757, 16'd23153}, {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
			send_reading(16'd27898, 19'd23843 << o);
			send_reading(16'd0, 19'd0);
			send_reading(16'hFFFF, 19'h7FFFF);
			send_reading(16'h5555, 19'h2AAAA);
			end_burst();
			drain();
		end

		// Zero pressure scale: AC4 cleared
		write_reg(RegAc34, {-16'sd14383, 16'd0});
		send_reading(16'd27898, 19'd23843);
		end_burst();
		drain();

		// Zero temperature divisor with nonzero calibration: MD cancels X1
		load_calibration(32'd0, {16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
			{16'd32768, 16'd100}, {16'd6190, 16'd4}, {-16'sd8711, -16'sd20});
		send_reading(16'd120, 19'd1000);
		end_burst();
		drain();

		// All-ones calibration, and writes past the last register
		load_calibration(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		write_reg(3'd6, 32'h1234_5678);
		write_reg(3'd7, 32'hFFFF_FFFF);
		send_reading(16'd0, 19'd0);
		send_reading(16'hFFFF, 19'h7FFFF);
		end_burst();
		drain();
		load_calibration(32'h0, 32'h8000_8000, 32'h8000_0000, 32'h0000_0000,
			32'h8000_8000, 32'h8000_8000);
		send_reading(16'hFFFF, 19'd0);
		end_burst();
		drain();

		// Random phases: typical calibration with jitter, and fully random
		for (int ph = 0; ph < 8; ph++) begin
			if (ph % 2 == 0) begin
				c1 = {16'(408 + $urandom_range(0, 200) - 100), 16'(-72 + $urandom_range(0, 20))};
				c2 = {16'(-14383 + $urandom_range(0, 2000)), 16'($urandom_range(30000, 34000))};
				c3 = {16'($urandom_range(30000, 34000)), 16'($urandom_range(20000, 26000))};
				c4 = {16'(6190 + $urandom_range(0, 400)), 16'($urandom_range(0, 8))};
				c5 = {16'(-8711 + $urandom_range(0, 400)), 16'($urandom_range(2500, 3200))};
			end else begin
				c1 = $urandom; c2 = $urandom; c3 = $urandom; c4 = $urandom; c5 = $urandom;
			end
			if (ph == 7)
				quiet = 1'b1;
			load_calibration($urandom, c1, c2, c3, c4, c5);
			random_readings(235);
			drain();
		end

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
